// File: rtl/core/zrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ZRLE tile decoder package
// Shared types and constants for the ZRLE tile decoder controller and datapath.
// ----------------------------------------------------------------------------
package zrle_pkg;

  localparam int unsigned RunMax = 8191;

  // register indexes
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_RECT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_BPP         = 3'd4;

  typedef enum logic [3:0] {
    PH_SUB,
    PH_RAW,
    PH_SOLID,
    PH_PAL_LOAD,
    PH_PACKED,
    PH_RLE_PIX,
    PH_RLE_LEN,
    PH_PRLE_RUN,
    PH_PRLE_LEN,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAINT,
    ST_EMIT
  } ctrl_state_t;

  // command from controller to datapath
  typedef struct packed {
    logic take_byte;   // process the accepted byte
    logic paint_step;  // emit one span chunk of the pending paint
    logic restart;     // configuration write
  } zrle_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic paint_busy;  // pixels remain to be painted for the current byte
    logic span_valid;  // a span is ready for the output register
  } zrle_sts_t;

  typedef struct packed {
    logic [15:0] span_col;
    logic [15:0] span_row;
    logic [6:0]  span_len;
    logic [23:0] pixel_value;
    logic        last_span;
    logic        bad_subencoding;
  } span_t;

endpackage

// File: rtl/core/zrle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ZRLE stream interfaces
// Valid/ready channels for input bytes and output spans.
// ----------------------------------------------------------------------------
interface zrle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface zrle_span_if;
  logic        valid;
  logic        ready;
  logic [15:0] span_col;
  logic [15:0] span_row;
  logic [6:0]  span_len;
  logic [23:0] pixel_value;
  logic        last_span;
  logic        bad_subencoding;
  modport source (output valid, output span_col, output span_row, output span_len,
                  output pixel_value, output last_span, output bad_subencoding,
                  input ready);
  modport sink (input valid, input span_col, input span_row, input span_len,
                input pixel_value, input last_span, input bad_subencoding,
                output ready);
endinterface

// File: rtl/core/zrle_tile_decoder_core.sv
`timescale 1ns / 1ps
// A byte that completes a span shows it on the output after a palette read and the output
// register. The input is not ready again until every span of the accepted byte is painted
// (each span a palette read then the output register), and it stays held while the output
// is held off.
// Reset: synchronous active-low rst_n clears registers (bytes_per_pixel to 4)
// and the tile walk; the palette store is not cleared.
// ----------------------------------------------------------------------------
// ZRLE tile decoder core
// Turns an inflated ZRLE rectangle byte stream into horizontal colour spans.
// ----------------------------------------------------------------------------
module zrle_tile_decoder_core #(
  parameter int unsigned TILE_SIZE     = 64,
  parameter int unsigned PALETTE_DEPTH = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  zrle_byte_if.sink   in_if,
  zrle_span_if.source out_if,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  zrle_pkg::zrle_cmd_t cmd;
  zrle_pkg::zrle_sts_t sts;
  zrle_pkg::span_t     span;
  logic                out_valid_r;
  zrle_pkg::span_t     out_r;
  logic                out_free;

  assign out_free = !out_valid_r || out_if.ready;

  zrle_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .out_free,
    .cfg_we,
    .sts,
    .cmd
  );

  zrle_dp #(.TILE_SIZE(TILE_SIZE), .PALETTE_DEPTH(PALETTE_DEPTH)) u_dp (
    .clk, .rst_n, .cmd,
    .data_byte (in_if.data_byte),
    .cfg_we, .cfg_index, .cfg_data,
    .sts, .span
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sts.span_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.span_valid) out_r <= span;
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.span_col        = out_r.span_col;
  assign out_if.span_row        = out_r.span_row;
  assign out_if.span_len        = out_r.span_len;
  assign out_if.pixel_value     = out_r.pixel_value;
  assign out_if.last_span       = out_r.last_span;
  assign out_if.bad_subencoding = out_r.bad_subencoding;

endmodule

// File: rtl/core/zrle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ZRLE controller
// Sequences byte acceptance, span painting and output handover.
// ----------------------------------------------------------------------------
module zrle_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_free,
  input  logic                  cfg_we,
  input  zrle_pkg::zrle_sts_t   sts,
  output zrle_pkg::zrle_cmd_t   cmd
);

  zrle_pkg::ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r <= zrle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.restart   = cfg_we;
    in_ready      = 1'b0;
    case (state_r)
      zrle_pkg::ST_IDLE: begin
        in_ready = !cfg_we;
        if (in_valid && !cfg_we) begin
          cmd.take_byte = 1'b1;
          state_nxt     = zrle_pkg::ST_PAINT;
        end
      end
      zrle_pkg::ST_PAINT: begin
        // issue a paint step while pixels remain and the output slot is free
        if (!sts.paint_busy) begin
          state_nxt = zrle_pkg::ST_IDLE;
        end else if (out_free) begin
          cmd.paint_step = 1'b1;
        end
      end
      default: state_nxt = zrle_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/zrle_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ZRLE datapath
// Tile walk, pixel gathering, palette store and span generation.
// ----------------------------------------------------------------------------
module zrle_dp #(
  parameter int unsigned TILE_SIZE     = 64,
  parameter int unsigned PALETTE_DEPTH = 127
) (
  input  logic                clk,
  input  logic                rst_n,
  input  zrle_pkg::zrle_cmd_t cmd,
  input  logic [7:0]          data_byte,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output zrle_pkg::zrle_sts_t sts,
  output zrle_pkg::span_t     span
);

  localparam int PW = $clog2(PALETTE_DEPTH);
  localparam int TW = $clog2(TILE_SIZE + 1);

  logic [15:0] origin_x_r, origin_y_r, rect_width_r, rect_height_r;
  logic [2:0]  bpp_r;
  logic [23:0] palette_mem [PALETTE_DEPTH];

  logic [15:0] tcol_r, trow_r;
  logic [TW-1:0] pcol_r, prow_r;
  logic [7:0]  mode_r;
  zrle_pkg::phase_t phase_r;
  logic [1:0]  bcnt_r;
  logic [23:0] acc_r;
  logic [12:0] run_r;
  logic [6:0]  cidx_r;

  // pending paint job
  logic        pbusy_r;
  logic [12:0] pn_r;       // pixels left
  logic [23:0] ppix_r;     // colour (direct)
  logic        ppal_r;     // colour from palette
  logic [6:0]  pidx_r;
  logic        pbad_r;
  logic        ppacked_r;  // packed byte: several single pixels
  logic [7:0]  pbyte_r;
  logic [2:0]  pleft_r;    // indexes left in packed byte after the current one

  logic [23:0] pal_q;

  // geometry
  logic [16:0] wrem, hrem;
  logic [TW-1:0] tw, th;
  always_comb begin
    wrem = {1'b0, rect_width_r} - {1'b0, tcol_r};
    hrem = {1'b0, rect_height_r} - {1'b0, trow_r};
    tw = (wrem > 17'(TILE_SIZE)) ? TW'(TILE_SIZE) : TW'(wrem);
    th = (hrem > 17'(TILE_SIZE)) ? TW'(TILE_SIZE) : TW'(hrem);
  end

  logic [1:0] cpp;
  always_comb begin
    if (bpp_r == 3'd0) cpp = 2'd1;
    else if (bpp_r >= 3'd4) cpp = 2'd3;
    else cpp = bpp_r[1:0];
  end

  logic [7:0] pal_size;
  assign pal_size = (mode_r <= 8'd16) ? mode_r : mode_r - 8'd128;

  // packed index width
  logic [2:0] pbits;
  always_comb begin
    if (mode_r >= 8'd5) pbits = 3'd4;
    else if (mode_r >= 8'd3) pbits = 3'd2;
    else pbits = 3'd1;
  end

  // current palette index for the paint step
  logic [6:0] cur_idx;
  logic [3:0] pk_idx;
  always_comb begin
    case (pbits)
      3'd4: pk_idx = pbyte_r[7:4];
      3'd2: pk_idx = {2'b00, pbyte_r[7:6]};
      default: pk_idx = {3'b000, pbyte_r[7]};
    endcase
    cur_idx = ppacked_r ? {3'b000, pk_idx} : pidx_r;
  end

  logic idx_ok;
  assign idx_ok = ({1'b0, cur_idx} < pal_size) && (32'(cur_idx) < PALETTE_DEPTH);

  // palette read, registered; index is stable the cycle before use
  always_ff @(posedge clk) begin
    pal_q <= palette_mem[PW'(cur_idx)];
  end

  logic [23:0] cur_pix;
  assign cur_pix = !ppal_r ? ppix_r : (idx_ok ? pal_q : 24'd0);

  // span chunk
  logic [TW-1:0] room;
  logic [12:0] chunk;
  logic        row_end, tile_end, rect_end;
  logic [15:0] tcol_n;
  logic [15:0] trow_n;
  logic [16:0] tcol_add, trow_add;
  always_comb begin
    room     = tw - pcol_r;
    chunk    = (13'(room) < pn_r) ? 13'(room) : pn_r;
    row_end  = (13'(pcol_r) + chunk) >= 13'(tw);
    tile_end = row_end && (prow_r + TW'(1) >= th);
    tcol_add = {1'b0, tcol_r} + 17'(TILE_SIZE);
    trow_add = {1'b0, trow_r} + 17'(TILE_SIZE);
    rect_end = 1'b0;
    tcol_n   = tcol_add[15:0];
    trow_n   = trow_r;
    if (tcol_add >= {1'b0, rect_width_r}) begin
      tcol_n = 16'd0;
      trow_n = trow_add[15:0];
      if (trow_add >= {1'b0, rect_height_r}) begin
        trow_n   = 16'd0;
        rect_end = 1'b1;
      end
    end
  end

  // a paint step gives a span only once step_ok_r shows that pal_q has settled
  logic step_ok_r;
  assign sts.paint_busy = pbusy_r;
  assign sts.span_valid = cmd.paint_step && step_ok_r;

  always_comb begin
    span.span_col        = origin_x_r + tcol_r + 16'(pcol_r);
    span.span_row        = origin_y_r + trow_r + 16'(prow_r);
    span.span_len        = pbad_r ? 7'd0 : 7'(chunk);
    span.pixel_value     = pbad_r ? 24'd0 : cur_pix;
    span.last_span       = !pbad_r && tile_end && rect_end;
    span.bad_subencoding = pbad_r;
  end

  logic [23:0] acc_new;
  logic [1:0]  bcnt_new;
  logic        gdone;
  always_comb begin
    case (bcnt_r)
      2'd0: acc_new = {16'd0, data_byte};
      2'd1: acc_new = {acc_r[23:16], data_byte, acc_r[7:0]};
      default: acc_new = {data_byte, acc_r[15:0]};
    endcase
    bcnt_new = bcnt_r + 2'd1;
    gdone    = bcnt_new >= cpp;
  end

  logic [13:0] run_sum;
  assign run_sum = {1'b0, run_r} + 14'(data_byte);

  logic geom_ok;
  assign geom_ok = (tw != '0) && (th != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0; origin_y_r <= '0; rect_width_r <= '0; rect_height_r <= '0;
      bpp_r <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        zrle_pkg::REG_ORIGIN_X:    origin_x_r    <= cfg_data;
        zrle_pkg::REG_ORIGIN_Y:    origin_y_r    <= cfg_data;
        zrle_pkg::REG_RECT_WIDTH:  rect_width_r  <= cfg_data;
        zrle_pkg::REG_RECT_HEIGHT: rect_height_r <= cfg_data;
        zrle_pkg::REG_BPP:         bpp_r         <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // palette write
  always_ff @(posedge clk) begin
    if (cmd.take_byte && phase_r == zrle_pkg::PH_PAL_LOAD && gdone &&
        32'(cidx_r) < PALETTE_DEPTH) begin
      palette_mem[PW'(cidx_r)] <= acc_new;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_we && cfg_index <= zrle_pkg::REG_BPP)) begin
      tcol_r <= '0; trow_r <= '0; pcol_r <= '0; prow_r <= '0;
      mode_r <= '0; phase_r <= zrle_pkg::PH_SUB; bcnt_r <= '0;
      acc_r <= '0; run_r <= '0; cidx_r <= '0;
      pbusy_r <= 1'b0; step_ok_r <= 1'b0;
    end else if (cmd.take_byte) begin
      step_ok_r <= 1'b0;
      ppacked_r <= 1'b0; ppal_r <= 1'b0; pbad_r <= 1'b0; pn_r <= 13'd1;
      case (phase_r)
        zrle_pkg::PH_SUB: begin
          if (rect_width_r != 16'd0 && rect_height_r != 16'd0) begin
            mode_r <= data_byte; bcnt_r <= '0; cidx_r <= '0; run_r <= '0;
            if (data_byte == 8'd0) phase_r <= zrle_pkg::PH_RAW;
            else if (data_byte == 8'd1) phase_r <= zrle_pkg::PH_SOLID;
            else if (data_byte <= 8'd16 || data_byte >= 8'd130)
              phase_r <= zrle_pkg::PH_PAL_LOAD;
            else if (data_byte == 8'h80) phase_r <= zrle_pkg::PH_RLE_PIX;
            else begin
              phase_r <= zrle_pkg::PH_ERROR;
              pbad_r  <= 1'b1;
              pbusy_r <= 1'b1;
            end
          end
        end
        zrle_pkg::PH_RAW, zrle_pkg::PH_SOLID, zrle_pkg::PH_RLE_PIX: begin
          acc_r  <= acc_new;
          bcnt_r <= gdone ? 2'd0 : bcnt_new;
          if (gdone) begin
            if (phase_r == zrle_pkg::PH_RLE_PIX) begin
              run_r   <= 13'd1;
              phase_r <= zrle_pkg::PH_RLE_LEN;
            end else begin
              ppix_r  <= acc_new;
              pn_r    <= (phase_r == zrle_pkg::PH_SOLID) ? 13'(tw) * 13'(th) : 13'd1;
              pbusy_r <= geom_ok;
            end
          end
        end
        zrle_pkg::PH_PAL_LOAD: begin
          acc_r  <= acc_new;
          bcnt_r <= gdone ? 2'd0 : bcnt_new;
          if (gdone) begin
            if ({1'b0, cidx_r} + 8'd1 >= pal_size) begin
              cidx_r  <= '0;
              phase_r <= (mode_r <= 8'd16) ? zrle_pkg::PH_PACKED : zrle_pkg::PH_PRLE_RUN;
            end else begin
              cidx_r <= cidx_r + 7'd1;
            end
          end
        end
        zrle_pkg::PH_PACKED: begin
          pbyte_r   <= data_byte;
          ppacked_r <= 1'b1;
          ppal_r    <= 1'b1;
          pleft_r   <= 3'd7 >> (pbits >> 1);
          pbusy_r   <= geom_ok;
        end
        zrle_pkg::PH_PRLE_RUN: begin
          if (data_byte[7]) begin
            cidx_r  <= data_byte[6:0];
            run_r   <= 13'd1;
            phase_r <= zrle_pkg::PH_PRLE_LEN;
          end else begin
            pidx_r  <= data_byte[6:0];
            ppal_r  <= 1'b1;
            pbusy_r <= geom_ok;
          end
        end
        zrle_pkg::PH_RLE_LEN, zrle_pkg::PH_PRLE_LEN: begin
          run_r <= (run_sum > 14'(zrle_pkg::RunMax)) ? 13'(zrle_pkg::RunMax) : run_sum[12:0];
          if (data_byte != 8'hFF) begin
            pn_r    <= (run_sum > 14'(zrle_pkg::RunMax)) ? 13'(zrle_pkg::RunMax)
                                                         : run_sum[12:0];
            ppix_r  <= acc_r;
            pidx_r  <= cidx_r;
            ppal_r  <= (phase_r == zrle_pkg::PH_PRLE_LEN);
            pbusy_r <= geom_ok;
            phase_r <= (phase_r == zrle_pkg::PH_RLE_LEN) ? zrle_pkg::PH_RLE_PIX
                                                         : zrle_pkg::PH_PRLE_RUN;
          end
        end
        default: ;
      endcase
    end else if (pbusy_r) begin
      // palette data is valid in the cycle after the index settles
      step_ok_r <= !sts.span_valid;
      if (sts.span_valid) begin
        if (pbad_r) begin
          pbusy_r <= 1'b0;
        end else begin
          // packed bytes paint single pixels, so keep one pixel pending
          if (!ppacked_r) pn_r <= pn_r - chunk;
          if (row_end) begin
            pcol_r <= '0;
            if (tile_end) begin
              prow_r <= '0;
              tcol_r <= tcol_n;
              trow_r <= trow_n;
              phase_r <= rect_end ? zrle_pkg::PH_DONE : zrle_pkg::PH_SUB;
              pbusy_r <= 1'b0;
            end else begin
              prow_r <= prow_r + TW'(1);
            end
          end else begin
            pcol_r <= pcol_r + TW'(chunk);
          end
          if (ppacked_r) begin
            pbyte_r <= pbyte_r << pbits;
            pleft_r <= pleft_r - 3'd1;
            if (pleft_r == 3'd0 || row_end) pbusy_r <= 1'b0;
          end else if (pn_r == chunk) begin
            pbusy_r <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/zrle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ZRLE port checker
// Port-level properties of the decoder core, bound to the top level.
// ----------------------------------------------------------------------------
module zrle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  span_len,
  input logic        last_span,
  input logic        bad_subencoding
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("span dropped");

  // hold a stalled request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("request dropped");

  // error results carry no length
  a_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_subencoding |-> span_len == 7'd0) else $error("bad len");

  // a span has a length
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !bad_subencoding |-> span_len != 7'd0) else $error("empty span");

  // error is never the last span
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_subencoding |-> !last_span) else $error("last on error");

endmodule

bind zrle_tile_decoder_core zrle_checker u_chk (
  .clk, .rst_n,
  .in_valid (in_if.valid), .in_ready (in_if.ready),
  .out_valid (out_if.valid), .out_ready (out_if.ready),
  .span_len (out_if.span_len), .last_span (out_if.last_span),
  .bad_subencoding (out_if.bad_subencoding)
);

// File: tb/sv/tb_zrle_tile_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ZRLE tile decoder core testbench
// Feeds well-formed ZRLE rectangle streams with random content, plus noise and
// unsupported tiles, under random idling on both sides. An in-bench span
// predictor works out the expected spans per accepted byte for comparison.
// ----------------------------------------------------------------------------
module tb_zrle_tile_decoder_core;

  localparam int unsigned TILE      = 64;
  localparam int unsigned PAL_DEPTH = 127;
  localparam int unsigned IDLE_LIMIT = 6000;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  zrle_byte_if in_if ();
  zrle_span_if out_if ();

  zrle_tile_decoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if.sink),
    .out_if    (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // stimulus and expectations
  logic [7:0] stream_q[$];
  zrle_pkg::span_t spans_due[$];
  int unsigned errors = 0;
  int unsigned spans_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned rand_bytes = 0;

  // span predictor state
  int unsigned org_x, org_y, rect_w, rect_h, bpp;
  logic [23:0] palette[PAL_DEPTH];
  int unsigned tile_col, tile_row, pix_col, pix_row, mode, byte_idx;
  int unsigned pix_acc, run_len, colour_idx, step_spans;
  zrle_pkg::phase_t phase;

  function automatic int unsigned compact_bytes();
    if (bpp == 0) return 1;
    if (bpp >= 4) return 3;
    return bpp;
  endfunction

  function automatic int unsigned cur_tile_w();
    if (tile_col >= rect_w) return 0;
    return (rect_w - tile_col > TILE) ? TILE : rect_w - tile_col;
  endfunction

  function automatic int unsigned cur_tile_h();
    if (tile_row >= rect_h) return 0;
    return (rect_h - tile_row > TILE) ? TILE : rect_h - tile_row;
  endfunction

  function automatic void restart_walk();
    tile_col = 0; tile_row = 0; pix_col = 0; pix_row = 0;
    mode = 0; phase = zrle_pkg::PH_SUB; byte_idx = 0;
    pix_acc = 0; run_len = 0; colour_idx = 0;
  endfunction

  function automatic void add_span(int unsigned col, int unsigned row, int unsigned len,
                                   int unsigned pix, bit bad);
    zrle_pkg::span_t s;
    s.span_col        = col[15:0];
    s.span_row        = row[15:0];
    s.span_len        = len[6:0];
    s.pixel_value     = pix[23:0];
    s.last_span       = 1'b0;
    s.bad_subencoding = bad;
    spans_due.push_back(s);
    step_spans++;
  endfunction

  function automatic int unsigned lookup_colour(int unsigned idx);
    int unsigned ncol;
    ncol = (mode <= 16) ? mode : mode - 128;
    if (idx >= ncol || idx >= PAL_DEPTH) return 0;
    return palette[idx];
  endfunction

  // advance to the next tile; 1 when the rectangle is complete
  function automatic bit advance_tile();
    pix_col = 0; pix_row = 0;
    tile_col += TILE;
    if (tile_col >= rect_w) begin
      tile_col = 0;
      tile_row += TILE;
      if (tile_row >= rect_h) begin
        tile_row = 0;
        phase = zrle_pkg::PH_DONE;
        return 1'b1;
      end
    end
    phase = zrle_pkg::PH_SUB;
    return 1'b0;
  endfunction

  // emit n pixels of one colour, cut at tile rows
  function automatic void paint_run(int unsigned pix, int unsigned n);
    int unsigned tw, th, len;
    tw = cur_tile_w();
    th = cur_tile_h();
    while (n > 0 && tw > 0 && th > 0) begin
      len = tw - pix_col;
      if (len > n) len = n;
      add_span(org_x + tile_col + pix_col, org_y + tile_row + pix_row, len, pix, 1'b0);
      pix_col += len;
      n -= len;
      if (pix_col >= tw) begin
        pix_col = 0;
        pix_row++;
        if (pix_row >= th) begin
          if (advance_tile() && step_spans > 0) spans_due[$].last_span = 1'b1;
          return;
        end
      end
    end
  endfunction

  function automatic bit collect_byte(int unsigned b);
    if (byte_idx == 0) pix_acc = b;
    else pix_acc |= b << (8 * (byte_idx & 3));
    pix_acc &= 32'hFF_FFFF;
    byte_idx++;
    if (byte_idx >= compact_bytes()) begin
      byte_idx = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void run_length_byte(int unsigned b, int unsigned pix,
                                          zrle_pkg::phase_t back);
    run_len += b;
    if (run_len > zrle_pkg::RunMax) run_len = zrle_pkg::RunMax;
    if (b != 255) begin
      phase = back;
      paint_run(pix, run_len);
    end
  endfunction

  function automatic void predict_spans(logic [7:0] data);
    int unsigned b, ncol, bits, per, mask, row, shift;
    b = data;
    step_spans = 0;
    case (phase)
      zrle_pkg::PH_SUB: begin
        if (rect_w != 0 && rect_h != 0) begin
          mode = b; byte_idx = 0; colour_idx = 0; run_len = 0;
          if (b == 0) phase = zrle_pkg::PH_RAW;
          else if (b == 1) phase = zrle_pkg::PH_SOLID;
          else if (b <= 16 || b >= 130) phase = zrle_pkg::PH_PAL_LOAD;
          else if (b == 128) phase = zrle_pkg::PH_RLE_PIX;
          else begin
            add_span(org_x + tile_col, org_y + tile_row, 0, 0, 1'b1);
            phase = zrle_pkg::PH_ERROR;
          end
        end
      end
      zrle_pkg::PH_RAW: if (collect_byte(b)) paint_run(pix_acc, 1);
      zrle_pkg::PH_SOLID: if (collect_byte(b)) paint_run(pix_acc, cur_tile_w() * cur_tile_h());
      zrle_pkg::PH_PAL_LOAD: begin
        if (collect_byte(b)) begin
          if (colour_idx < PAL_DEPTH) palette[colour_idx] = pix_acc[23:0];
          colour_idx++;
          ncol = (mode <= 16) ? mode : mode - 128;
          if (colour_idx >= ncol) begin
            colour_idx = 0;
            phase = (mode <= 16) ? zrle_pkg::PH_PACKED : zrle_pkg::PH_PRLE_RUN;
          end
        end
      end
      zrle_pkg::PH_PACKED: begin
        bits = (mode >= 5) ? 4 : ((mode >= 3) ? 2 : 1);
        per = 8 / bits;
        mask = (1 << bits) - 1;
        row = pix_row;
        for (int unsigned i = 0; i < per; i++) begin
          shift = 8 - bits * (i + 1);
          paint_run(lookup_colour((b >> shift) & mask), 1);
          if (phase != zrle_pkg::PH_PACKED || pix_row != row) break;
        end
      end
      zrle_pkg::PH_RLE_PIX: begin
        if (collect_byte(b)) begin
          run_len = 1;
          phase = zrle_pkg::PH_RLE_LEN;
        end
      end
      zrle_pkg::PH_RLE_LEN: run_length_byte(b, pix_acc, zrle_pkg::PH_RLE_PIX);
      zrle_pkg::PH_PRLE_RUN: begin
        if (b & 8'h80) begin
          colour_idx = b & 8'h7F;
          run_len = 1;
          phase = zrle_pkg::PH_PRLE_LEN;
        end else begin
          paint_run(lookup_colour(b), 1);
        end
      end
      zrle_pkg::PH_PRLE_LEN: run_length_byte(b, lookup_colour(colour_idx), zrle_pkg::PH_PRLE_RUN);
      default: ;
    endcase
  endfunction

  // byte driver: random gaps, with stretches of back-to-back requests
  int unsigned in_gap = 0;
  int unsigned in_count = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_spans(in_if.data_byte);
        in_count++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (stream_q.size() > 0) begin
          in_if.data_byte <= stream_q.pop_front();
          in_if.valid <= 1'b1;
          in_gap = ((in_count / 60) % 3 == 1) ? 0 : $urandom_range(0, 7);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // span monitor: check against the oldest expectation, hold off at random
  int unsigned out_gap = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        zrle_pkg::span_t got, want;
        got.span_col        = out_if.span_col;
        got.span_row        = out_if.span_row;
        got.span_len        = out_if.span_len;
        got.pixel_value     = out_if.pixel_value;
        got.last_span       = out_if.last_span;
        got.bad_subencoding = out_if.bad_subencoding;
        spans_seen++;
        if (spans_due.size() == 0) begin
          $display("%0t: unexpected span, actual %p", $time, got);
          errors++;
        end else begin
          want = spans_due.pop_front();
          if (got.span_col !== want.span_col || got.span_row !== want.span_row ||
              got.span_len !== want.span_len || got.pixel_value !== want.pixel_value ||
              got.last_span !== want.last_span ||
              got.bad_subencoding !== want.bad_subencoding) begin
            $display("%0t: span mismatch, expected %p, actual %p", $time, want, got);
            errors++;
          end
        end
        out_gap = ((spans_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, 7);
        if (spans_seen == 30 && !held_once) begin
          held_once = 1'b1;
          hold_left = 400;
        end
      end else if (out_gap > 0) begin
        out_gap--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (out_gap == 0);
      end
    end
  end

  // watchdog on cycles with no request moved on either side
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_zrle_tile_decoder_core NOT OK");
      $finish;
    end
  end

  // hold until the block has drained every expected span
  task automatic wait_drained();
    while (stream_q.size() != 0 || in_if.valid || spans_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      zrle_pkg::REG_ORIGIN_X:    org_x = value;
      zrle_pkg::REG_ORIGIN_Y:    org_y = value;
      zrle_pkg::REG_RECT_WIDTH:  rect_w = value;
      zrle_pkg::REG_RECT_HEIGHT: rect_h = value;
      zrle_pkg::REG_BPP:         bpp = value[2:0];
      default: ;
    endcase
    restart_walk();
    @(posedge clk);
  endtask

  task automatic set_rect(int unsigned ox, int unsigned oy, int unsigned w, int unsigned h,
                          int unsigned bp);
    wait_drained();
    write_reg(zrle_pkg::REG_ORIGIN_X, 16'(ox));
    write_reg(zrle_pkg::REG_ORIGIN_Y, 16'(oy));
    write_reg(zrle_pkg::REG_RECT_WIDTH, 16'(w));
    write_reg(zrle_pkg::REG_RECT_HEIGHT, 16'(h));
    write_reg(zrle_pkg::REG_BPP, {13'($urandom), bp[2:0]});
    cfg_we <= 1'b0;
  endtask

  task automatic send(input logic [7:0] b);
    stream_q.push_back(b);
    rand_bytes++;
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send(8'($urandom_range(0, 255)));
  endtask

  // run lengths as 255-continued length bytes
  task automatic send_length(int unsigned run);
    int unsigned rest;
    rest = run - 1;
    while (rest >= 255) begin
      send(8'hFF);
      rest -= 255;
    end
    send(8'(rest));
  endtask

  // long runs on large tiles keep the byte count down
  function automatic int unsigned pick_run(int unsigned left);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return $urandom_range(300, 9000);
    if (r == 1) return left + $urandom_range(1, 20);
    if (left > 200) return $urandom_range(left / 2, left);
    return $urandom_range(1, (left < 40) ? left : 40);
  endfunction

  // a random tile, at times unsupported if allow_bad; 1 when it ended decoding
  task automatic send_tile(int unsigned tw, int unsigned th, int unsigned cpp, bit allow_bad,
                           output bit stopped);
    int unsigned kind, ncol, bits, left, run, idx;
    stopped = 1'b0;
    kind = $urandom_range(0, 11);
    if (kind == 11 && allow_bad) begin
      send(($urandom_range(0, 3) == 0) ? 8'd129 : 8'($urandom_range(17, 127)));
      send_random($urandom_range(0, 3));
      stopped = 1'b1;
      return;
    end
    if (kind <= 1 && tw * th <= 24) begin
      send(8'd0);
      send_random(tw * th * cpp);
    end else if (kind <= 4 && th * ((tw * 4 + 7) / 8) <= 48) begin
      ncol = $urandom_range(2, 16);
      bits = (ncol >= 5) ? 4 : ((ncol >= 3) ? 2 : 1);
      send(8'(ncol));
      send_random(ncol * cpp);
      send_random(th * ((tw * bits + 7) / 8));
    end else if (kind <= 6) begin
      send(8'd128);
      left = tw * th;
      while (left > 0) begin
        send_random(cpp);
        run = pick_run(left);
        send_length(run);
        left = (run >= left) ? 0 : left - run;
      end
    end else if (kind <= 9) begin
      ncol = ($urandom_range(0, 15) == 0) ? 127 : $urandom_range(2, 8);
      send(8'(128 + ncol));
      send_random(ncol * cpp);
      left = tw * th;
      while (left > 0) begin
        idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                          : $urandom_range(0, ncol - 1);
        if ($urandom_range(0, 1) == 0) begin
          send({1'b0, idx[6:0]});
          left--;
        end else begin
          send({1'b1, idx[6:0]});
          run = pick_run(left);
          send_length(run);
          left = (run >= left) ? 0 : left - run;
        end
      end
    end else begin
      send(8'd1);
      send_random(cpp);
    end
  endtask

  task automatic send_rect(int unsigned w, int unsigned h, int unsigned cpp);
    int unsigned tiles;
    bit stopped;
    tiles = 0;
    for (int unsigned ty = 0; ty < h; ty += TILE) begin
      for (int unsigned tx = 0; tx < w; tx += TILE) begin
        if (tiles == 4) return;
        send_tile((w - tx > TILE) ? TILE : w - tx, (h - ty > TILE) ? TILE : h - ty,
                  cpp, 1'b1, stopped);
        tiles++;
        if (stopped) return;
      end
    end
    if ($urandom_range(0, 3) == 0) send_random(2);
  endtask

  initial begin
    int unsigned w, h, bp, r;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (palette[i]) palette[i] = '0;
    org_x = 0; org_y = 0; rect_w = 0; rect_h = 0; bpp = 4;
    restart_walk();
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty rectangle after reset: bytes ignored
    send(8'h00); send(8'hFF); send(8'h01);
    // raw at the far screen corner, coordinates wrap, then a stray byte
    set_rect(16'hFFFF, 16'hFFFF, 2, 1, 1);
    send(8'h00); send(8'h00); send(8'hFF); send(8'hAA);
    // solid with two-byte pixels
    set_rect(10, 20, 3, 2, 2);
    send(8'h01); send(8'h34); send(8'h12);
    // packed two colours with row padding
    set_rect(0, 0, 4, 2, 0);
    send(8'h02); send(8'h10); send(8'h20); send(8'hA0); send(8'h5F);
    // plain run with a 255 length byte, cut at the tile end
    set_rect(5, 5, 4, 1, 5);
    send(8'd128); send(8'h11); send(8'h22); send(8'h33); send(8'hFF); send(8'h00);
    // palette run: out-of-range index, run, single indexes
    set_rect(0, 7, 4, 1, 1);
    send(8'd130); send(8'h11); send(8'h22); send(8'h85); send(8'h01); send(8'h01);
    send(8'h00);
    // unsupported subencodings stop decoding; a zero-width rectangle ignores its byte
    set_rect(100, 0, 8, 8, 3);
    send(8'd17); send(8'h01);
    set_rect(0, 0, 8, 8, 3);
    send(8'd129);
    set_rect(0, 0, 0, 5, 4);
    send(8'h01);

    // random rectangles
    rand_bytes = 0;
    while (rand_bytes < 170) begin
      r = $urandom_range(0, 19);
      if (r < 13) begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 10);
      end else if (r < 16) begin
        w = $urandom_range(60, 130);
        h = $urandom_range(1, 3);
        if (r == 15) begin
          r = w; w = h; h = r;
        end
      end else if (r < 17) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
        h = (w == 0) ? $urandom_range(0, 5) : 0;
      end else if (r < 18) begin
        w = 65535;
        h = $urandom_range(1, 2);
      end else begin
        w = 64;
        h = 64;
      end
      bp = $urandom_range(0, 7);
      set_rect($urandom_range(0, 1) ? $urandom_range(0, 65535) : 65535 - $urandom_range(0, 20),
               $urandom_range(0, 65535), w, h, bp);
      if (w == 0 || h == 0) send_random(3);
      else send_rect(w, h, (bp == 0) ? 1 : ((bp >= 4) ? 3 : bp));
    end

    wait_drained();
    if (errors == 0) begin
      $display("tb_zrle_tile_decoder_core OK");
    end else begin
      $display("tb_zrle_tile_decoder_core NOT OK");
    end
    $finish;
  end

endmodule
